>>> sv/owsp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// owsp_pkg
// Shared constants, register codes and the configuration bundle of the
// omni wheel speed packer.
// ----------------------------------------------------------------------------
package owsp_pkg;

  localparam int TURN_FRAC_BITS = 12;
  localparam int DEN_FACTOR     = 129;
  localparam int QBITS          = 6;
  localparam int LANES          = 4;

  localparam longint Q30_HALF_SQRT3 = 64'sd929887697;
  localparam longint Q30_HALF_SQRT2 = 64'sd759250125;
  localparam longint Q30_HALF       = 64'sd536870912;

  localparam logic [4:0] SPEED_LIMIT_RESET = 5'd30;
  localparam logic [7:0] LEVER_ARM_RESET   = 8'd90;

  typedef enum logic [0:0] {
    REG_SPEED_LIMIT = 1'b0,
    REG_LEVER_ARM   = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic [4:0] speed_limit;
    logic [7:0] lever_arm;
  } cfg_t;

  // Rounds a Q2.30 coefficient to nearest at f fractional bits.
  function automatic int coef_q(longint q30, int f);
    longint r;
    r = (q30 + (longint'(1) << (29 - f))) >>> (30 - f);
    return int'(r);
  endfunction

endpackage
`default_nettype wire

>>> sv/owsp_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// owsp_front
// Four-stage front end: wheel numerators, largest magnitude, limit test and
// selection of dividend and divisor for each wheel.
// ----------------------------------------------------------------------------
module owsp_front import owsp_pkg::*; #(
  parameter int COEF_FRAC_BITS = 14,
  localparam int NW = COEF_FRAC_BITS + 34,
  localparam int RW = NW + 6,
  localparam int QW = 16 + NW + LANES + LANES * RW
) (
  input  wire              clk,
  input  wire              rst,
  input  cfg_t             cfg,
  input  wire              in_valid,
  output logic             in_ready,
  input  wire signed [15:0] velocity_x,
  input  wire signed [15:0] velocity_y,
  input  wire signed [15:0] turn_rate,
  input  wire              chip_mode,
  input  wire [7:0]        kick_strength,
  input  wire [7:0]        robot_id,
  output logic             out_valid,
  input  wire              out_ready,
  output logic [QW-1:0]    out_data
);

  localparam int F  = COEF_FRAC_BITS;
  localparam int CW = F + 2;
  localparam int PW = CW + 16;
  localparam int LW = F + 25;
  localparam int S3 = coef_q(Q30_HALF_SQRT3, F);
  localparam int S2 = coef_q(Q30_HALF_SQRT2, F);
  localparam int H  = coef_q(Q30_HALF, F);
  localparam logic signed [CW-1:0] CX [LANES] = '{CW'(-S3), CW'(-S2), CW'(S2), CW'(S3)};
  localparam logic signed [CW-1:0] CY [LANES] = '{CW'(-H), CW'(S2), CW'(S2), CW'(-H)};
  localparam logic [NW-1:0] DEN = NW'(DEN_FACTOR) << (F + TURN_FRAC_BITS);

  logic en;
  logic v1, v2, v3, v4;

  logic signed [PW-1:0] px [LANES];
  logic signed [PW-1:0] py [LANES];
  logic signed [24:0]   pw;
  logic [7:0]           kick1, kick2, kick3, kick4;
  logic [7:0]           id1, id2, id3, id4;

  logic [NW-1:0]        mag2 [LANES];
  logic [LANES-1:0]     neg2, neg3, neg4;

  logic [NW-1:0]        maxn3;
  logic [LW-1:0]        limden3;
  logic [RW-1:0]        n3 [LANES];
  logic [RW-1:0]        nl3 [LANES];

  logic [NW-1:0]        d4;
  logic [RW-1:0]        n4 [LANES];

  logic signed [NW-1:0] num [LANES];
  logic [NW-1:0]        m01, m23, mall;
  logic                 scale;

  assign en       = !v4 || out_ready;
  assign in_ready = en;
  assign out_valid = v4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_comb begin
    logic signed [PW:0]   sxy;
    logic signed [NW-1:0] a;
    logic signed [NW-1:0] b;
    for (int i = 0; i < LANES; i++) begin
      sxy = {px[i][PW-1], px[i]} + {py[i][PW-1], py[i]};
      a = NW'(sxy) <<< (TURN_FRAC_BITS + 1);
      b = ((NW'(pw) <<< 7) + NW'(pw)) <<< F;
      num[i] = a - b;
    end
  end

  assign m01   = (mag2[0] > mag2[1]) ? mag2[0] : mag2[1];
  assign m23   = (mag2[2] > mag2[3]) ? mag2[2] : mag2[3];
  assign mall  = (m01 > m23) ? m01 : m23;
  assign scale = maxn3 > NW'(limden3);

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < LANES; i++) begin
        px[i] <= PW'(CX[i] * velocity_x);
        py[i] <= PW'(CY[i] * velocity_y);
      end
      pw    <= 25'($signed({1'b0, cfg.lever_arm}) * turn_rate);
      kick1 <= {kick_strength[2:0], chip_mode, 4'b0000};
      id1   <= robot_id;

      for (int i = 0; i < LANES; i++) begin
        neg2[i] <= num[i][NW-1];
        mag2[i] <= num[i][NW-1] ? (~num[i] + NW'(1)) : num[i];
      end
      kick2 <= kick1;
      id2   <= id1;

      maxn3   <= mall;
      limden3 <= LW'(cfg.speed_limit * DEN_FACTOR) << (F + TURN_FRAC_BITS);
      for (int i = 0; i < LANES; i++) begin
        n3[i]  <= RW'({mag2[i], 1'b0});
        nl3[i] <= RW'({mag2[i], 1'b0}) * RW'(cfg.speed_limit);
      end
      neg3  <= neg2;
      kick3 <= kick2;
      id3   <= id2;

      d4 <= scale ? maxn3 : DEN;
      for (int i = 0; i < LANES; i++) begin
        n4[i] <= scale ? nl3[i] : n3[i];
      end
      neg4  <= neg3;
      kick4 <= kick3;
      id4   <= id3;
    end
  end

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      out_data[i*RW +: RW] = n4[i];
    end
    out_data[LANES*RW +: LANES] = neg4;
    out_data[LANES*RW+LANES +: NW] = d4;
    out_data[QW-16 +: 8] = id4;
    out_data[QW-8 +: 8]  = kick4;
  end

endmodule
`default_nettype wire

>>> sv/owsp_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// owsp_queue
// Short first-in first-out queue between the front end and the divider.
// ----------------------------------------------------------------------------
module owsp_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire             clk,
  input  wire             rst,
  input  wire             in_valid,
  output logic            in_ready,
  input  wire [WIDTH-1:0] in_data,
  output logic            out_valid,
  input  wire             out_ready,
  output logic [WIDTH-1:0] out_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wp, rp;
  logic [AW:0]      count;
  logic             push, pop;

  assign in_ready  = count != (AW+1)'(DEPTH);
  assign out_valid = count != '0;
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_data  = mem[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wp <= (wp == AW'(DEPTH - 1)) ? '0 : wp + AW'(1);
      end
      if (pop) begin
        rp <= (rp == AW'(DEPTH - 1)) ? '0 : rp + AW'(1);
      end
      count <= count + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (AW+1)'(DEPTH))
    else $error("queue occupancy exceeds its depth");

endmodule
`default_nettype wire

>>> sv/owsp_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// owsp_back
// Pipelined restoring divider, one quotient bit per stage for all four
// wheels, followed by rounding and byte packing into the output register.
// ----------------------------------------------------------------------------
module owsp_back import owsp_pkg::*; #(
  parameter int COEF_FRAC_BITS = 14,
  localparam int NW = COEF_FRAC_BITS + 34,
  localparam int RW = NW + 6,
  localparam int QW = 16 + NW + LANES + LANES * RW
) (
  input  wire           clk,
  input  wire           rst,
  input  wire           in_valid,
  output logic          in_ready,
  input  wire [QW-1:0]  in_data,
  output logic          out_valid,
  input  wire           out_ready,
  output logic [39:0]   out_data
);

  logic en;

  logic                 vld  [QBITS];
  logic [RW-1:0]        rem  [QBITS][LANES];
  logic [QBITS-1:0]     quo  [QBITS][LANES];
  logic [LANES-1:0]     negs [QBITS];
  logic [NW-1:0]        dv   [QBITS];
  logic [7:0]           kick [QBITS];
  logic [7:0]           id   [QBITS];

  logic [RW-1:0]        rem_nx [QBITS][LANES];
  logic [QBITS-1:0]     quo_nx [QBITS][LANES];
  logic [5:0]           wheel  [LANES];

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  always_comb begin
    logic [RW-1:0]    r_in;
    logic [QBITS-1:0] q_in;
    logic [NW-1:0]    d_in;
    logic [RW-1:0]    trial;
    logic             ge;
    for (int j = 0; j < QBITS; j++) begin
      for (int i = 0; i < LANES; i++) begin
        if (j == 0) begin
          r_in = in_data[i*RW +: RW];
          q_in = '0;
          d_in = in_data[LANES*RW+LANES +: NW];
        end else begin
          r_in = rem[j-1][i];
          q_in = quo[j-1][i];
          d_in = dv[j-1];
        end
        trial = RW'(d_in) << (QBITS - 1 - j);
        ge = r_in >= trial;
        rem_nx[j][i] = ge ? (r_in - trial) : r_in;
        quo_nx[j][i] = {q_in[QBITS-2:0], ge};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < QBITS; j++) begin
        vld[j] <= 1'b0;
      end
      out_valid <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
      for (int j = 1; j < QBITS; j++) begin
        vld[j] <= vld[j-1];
      end
      out_valid <= vld[QBITS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < QBITS; j++) begin
        for (int i = 0; i < LANES; i++) begin
          rem[j][i] <= rem_nx[j][i];
          quo[j][i] <= quo_nx[j][i];
        end
      end
      negs[0] <= in_data[LANES*RW +: LANES];
      dv[0]   <= in_data[LANES*RW+LANES +: NW];
      id[0]   <= in_data[QW-16 +: 8];
      kick[0] <= in_data[QW-8 +: 8];
      for (int j = 1; j < QBITS; j++) begin
        negs[j] <= negs[j-1];
        dv[j]   <= dv[j-1];
        id[j]   <= id[j-1];
        kick[j] <= kick[j-1];
      end
    end
  end

  // Ceiling of the signed quotient, then floor of half of it.
  always_comb begin
    logic signed [7:0] c;
    logic [7:0]        q8;
    for (int i = 0; i < LANES; i++) begin
      q8 = {2'b00, quo[QBITS-1][i]};
      if (negs[QBITS-1][i]) begin
        c = -$signed(q8);
      end else begin
        c = $signed(q8 + 8'(rem[QBITS-1][i] != '0));
      end
      wheel[i] = 6'(c >>> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= {kick[QBITS-1],
                   wheel[2][1:0], wheel[3],
                   wheel[1][3:0], wheel[2][5:2],
                   wheel[0], wheel[1][5:4],
                   id[QBITS-1]};
    end
  end

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    vld[QBITS-1] |->
      (rem[QBITS-1][0] < RW'(dv[QBITS-1])) && (rem[QBITS-1][1] < RW'(dv[QBITS-1])) &&
      (rem[QBITS-1][2] < RW'(dv[QBITS-1])) && (rem[QBITS-1][3] < RW'(dv[QBITS-1])))
    else $error("divider remainder not below divisor");

  a_result_from_pipe: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(vld[QBITS-1]))
    else $error("result appeared without a finished division");

  a_entry_tracked: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> vld[0])
    else $error("accepted transfer lost at divider entry");

endmodule
`default_nettype wire

>>> sv/omni_wheel_speed_packer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// omni_wheel_speed_packer
// Four-wheel omni drive command packer: wheel speeds from body velocity and
// turn rate, common scaling to the speed limit, rounding and byte packing.
// ----------------------------------------------------------------------------
//  channel  | direction | contents
//  s_axis   | in        | one robot command per transfer
//  m_axis   | out       | id, three wheel bytes and kick byte per transfer
//  wr_*     | in        | register write, index 0 speed_limit, 1 wheel_lever_arm
//
// One command is accepted per cycle unless the output stalls; a command passes
// four front stages, one register in the queue, six divider stages and the
// output register. The six-stage restoring divider sets the back end depth.
// Reset clears the registers to speed_limit 30 and wheel_lever_arm 90.
// A stalled output stops the back end; the queue then lets the front fill.
// ----------------------------------------------------------------------------
module omni_wheel_speed_packer import owsp_pkg::*; #(
  parameter int COEF_FRAC_BITS = 14,
  parameter int QUEUE_DEPTH    = 2
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  // velocity_x, velocity_y, turn_rate, chip_mode, kick_strength, robot_id, zeros
  input  wire [71:0]  s_axis_tdata,
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  // id_byte, wheel_byte_a, wheel_byte_b, wheel_byte_c, kick_byte
  output logic [39:0] m_axis_tdata,
  input  wire         wr_en,
  input  wire [0:0]   wr_index,
  input  wire [7:0]   wr_data
);

  localparam int NW = COEF_FRAC_BITS + 34;
  localparam int RW = NW + 6;
  localparam int QW = 16 + NW + LANES + LANES * RW;

  cfg_t          cfg;
  logic          f_valid, f_ready, b_valid, b_ready;
  logic [QW-1:0] f_data, b_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.speed_limit <= SPEED_LIMIT_RESET;
      cfg.lever_arm   <= LEVER_ARM_RESET;
    end else if (wr_en) begin
      case (reg_index_t'(wr_index))
        REG_SPEED_LIMIT: cfg.speed_limit <= wr_data[4:0];
        REG_LEVER_ARM:   cfg.lever_arm   <= wr_data;
        default: ;
      endcase
    end
  end

  owsp_front #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .in_valid      (s_axis_tvalid),
    .in_ready      (s_axis_tready),
    .velocity_x    (s_axis_tdata[15:0]),
    .velocity_y    (s_axis_tdata[31:16]),
    .turn_rate     (s_axis_tdata[47:32]),
    .chip_mode     (s_axis_tdata[48]),
    .kick_strength (s_axis_tdata[56:49]),
    .robot_id      (s_axis_tdata[64:57]),
    .out_valid     (f_valid),
    .out_ready     (f_ready),
    .out_data      (f_data)
  );

  owsp_queue #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_data   (f_data),
    .out_valid (b_valid),
    .out_ready (b_ready),
    .out_data  (b_data)
  );

  owsp_back #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (b_valid),
    .in_ready  (b_ready),
    .in_data   (b_data),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata)
  );

endmodule
`default_nettype wire

>>> tb/omni_wheel_speed_packer_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// omni_wheel_speed_packer_test
// Self-checking bench for the omni wheel speed packer. Robot commands are
// streamed in under random idling on both sides, across several register
// settings. Every accepted command is turned into the expected frame bytes
// by an exact integer model of the wheel kinematics, and every output
// transfer is compared field by field with the oldest expected frame.
// ----------------------------------------------------------------------------
module omni_wheel_speed_packer_test;
  import owsp_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int COEF_BITS   = 14;
  localparam int DRAIN_WAIT  = 30;

  class frame_scoreboard;
    logic [39:0] frames[$];
    logic [4:0]  limit;
    logic [7:0]  arm;
    int          errors;

    function new();
      limit  = SPEED_LIMIT_RESET;
      arm    = LEVER_ARM_RESET;
      errors = 0;
    endfunction

    function longint round_coef(longint q30);
      return (q30 + (longint'(1) << (29 - COEF_BITS))) >>> (30 - COEF_BITS);
    endfunction

    function longint div_up(longint a, longint b);
      longint q;
      q = a / b;
      if ((a % b) != 0 && a > 0) q++;
      return q;
    endfunction

    function longint halve_down(longint c);
      longint q;
      q = c / 2;
      if ((c % 2) != 0 && c < 0) q--;
      return q;
    endfunction

    function logic [39:0] wheel_frame(logic [71:0] cmd);
      longint vx, vy, w, s3, s2, h, den, lim, peak, c;
      longint cx[4], cy[4], num[4];
      logic [5:0] sp[4];
      vx   = longint'($signed(cmd[15:0]));
      vy   = longint'($signed(cmd[31:16]));
      w    = longint'($signed(cmd[47:32]));
      s3   = round_coef(Q30_HALF_SQRT3);
      s2   = round_coef(Q30_HALF_SQRT2);
      h    = round_coef(Q30_HALF);
      den  = longint'(129) << (COEF_BITS + 12);
      lim  = longint'(limit);
      peak = 0;
      cx[0] = -s3; cy[0] = -h;
      cx[1] = -s2; cy[1] = s2;
      cx[2] = s2;  cy[2] = s2;
      cx[3] = s3;  cy[3] = -h;
      for (int i = 0; i < 4; i++) begin
        num[i] = (cx[i] * vx + cy[i] * vy) * 2 * 4096
                 - longint'(arm) * w * 129 * (longint'(1) << COEF_BITS);
        if ((num[i] < 0 ? -num[i] : num[i]) > peak) peak = num[i] < 0 ? -num[i] : num[i];
      end
      for (int i = 0; i < 4; i++) begin
        if (peak > lim * den) c = div_up(2 * num[i] * lim, peak);
        else c = div_up(2 * num[i], den);
        sp[i] = 6'(halve_down(c));
      end
      return {{cmd[51:49], cmd[48], 4'h0},
              {sp[2][1:0], sp[3]},
              {sp[1][3:0], sp[2][5:2]},
              {sp[0], sp[1][5:4]},
              cmd[64:57]};
    endfunction

    function void note_command(logic [71:0] cmd);
      frames.push_back(wheel_frame(cmd));
    endfunction

    function void check_frame(logic [39:0] got);
      logic [39:0] want;
      string names[5];
      names = '{"id_byte", "wheel_byte_a", "wheel_byte_b", "wheel_byte_c", "kick_byte"};
      if (frames.size() == 0) begin
        $display("%0t: unexpected frame %h", $time, got);
        errors++;
        return;
      end
      want = frames.pop_front();
      for (int i = 0; i < 5; i++)
        if (want[8*i +: 8] !== got[8*i +: 8]) begin
          $display("%0t: %s expected %h actual %h", $time, names[i],
                   want[8*i +: 8], got[8*i +: 8]);
          errors++;
        end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic        wr_en = 1'b0;
  logic [0:0]  wr_index = '0;
  logic [7:0]  wr_data = '0;

  frame_scoreboard frames_sb = new();
  bit quiet = 1'b0;
  int stall_left = 0;
  int cycles = 0;

  omni_wheel_speed_packer dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("omni_wheel_speed_packer_test: errors");
      $finish;
    end
    if (!rst && s_axis_tvalid && s_axis_tready) frames_sb.note_command(s_axis_tdata);
    if (!rst && m_axis_tvalid && m_axis_tready) frames_sb.check_frame(m_axis_tdata);
  end

  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left--;
    end else begin
      m_axis_tready <= 1'b1;
      if (!quiet && $urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 14);
    end
  end

  task automatic send_command(logic [15:0] vx, logic [15:0] vy, logic [15:0] w,
                              logic mode, logic [7:0] power, logic [7:0] id);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    s_axis_tdata  = {7'h0, id, power, mode, w, vy, vx};
    s_axis_tvalid = 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
  endtask

  task automatic write_reg(reg_index_t idx, logic [7:0] val);
    s_axis_tvalid = 1'b0;
    while (frames_sb.frames.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
    wr_en    = 1'b1;
    wr_index = idx;
    wr_data  = val;
    @(negedge clk);
    wr_en = 1'b0;
    if (idx == REG_SPEED_LIMIT) frames_sb.limit = val[4:0];
    else frames_sb.arm = val;
  endtask

  function automatic logic [15:0] pick_value(bit rate);
    case ($urandom_range(0, 3))
      0: return 16'($urandom);
      1: return rate ? 16'($signed($urandom_range(0, 400)) - 200)
                     : 16'($signed($urandom_range(0, 8000)) - 4000);
      2: return 16'($signed($urandom_range(0, 60)) - 30);
      default: return rate ? 16'($signed($urandom_range(0, 40)) - 20)
                           : 16'($signed($urandom_range(0, 2000)) - 1000);
    endcase
  endfunction

  task automatic random_commands(int count);
    repeat (count)
      send_command(pick_value(0), pick_value(0), pick_value(1),
                   1'($urandom), 8'($urandom), 8'($urandom));
  endtask

  initial begin
    repeat (4) @(negedge clk);
    rst = 1'b0;

    send_command(16'h0000, 16'h0000, 16'h0000, 1'b0, 8'h00, 8'h00);
    send_command(16'h7FFF, 16'h0000, 16'h0000, 1'b1, 8'hFF, 8'hFF);
    send_command(16'h8000, 16'h0000, 16'h0000, 1'b0, 8'h07, 8'h5A);
    send_command(16'h0000, 16'h7FFF, 16'h0000, 1'b1, 8'h08, 8'hA5);
    send_command(16'h0000, 16'h8000, 16'h0000, 1'b0, 8'hF8, 8'h01);
    send_command(16'h0000, 16'h0000, 16'h7FFF, 1'b1, 8'h55, 8'h80);
    send_command(16'h0000, 16'h0000, 16'h8000, 1'b0, 8'hAA, 8'h7F);
    send_command(16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1, 8'h03, 8'h10);
    send_command(16'h8000, 16'h8000, 16'h8000, 1'b0, 8'h04, 8'h20);
    send_command(16'h0040, 16'hFFC0, 16'h0001, 1'b1, 8'h01, 8'h02);
    send_command(16'h0020, 16'h0000, 16'hFFFF, 1'b0, 8'h02, 8'h03);
    send_command(16'hFFFF, 16'h0001, 16'h0000, 1'b1, 8'h06, 8'h04);
    send_command(16'h0100, 16'h0100, 16'h0000, 1'b0, 8'h05, 8'h05);
    random_commands(90);

    write_reg(REG_SPEED_LIMIT, 8'd1);
    write_reg(REG_LEVER_ARM, 8'd1);
    send_command(16'h0050, 16'h0000, 16'h0000, 1'b1, 8'h01, 8'h11);
    send_command(16'h0000, 16'h0000, 16'h0100, 1'b0, 8'h02, 8'h12);
    random_commands(70);

    write_reg(REG_SPEED_LIMIT, 8'd31);
    write_reg(REG_LEVER_ARM, 8'd255);
    random_commands(70);

    write_reg(REG_SPEED_LIMIT, 8'd0);
    write_reg(REG_LEVER_ARM, 8'd0);
    send_command(16'h0000, 16'h0000, 16'h7FFF, 1'b1, 8'hFF, 8'h21);
    random_commands(40);

    for (int k = 0; k < 3; k++) begin
      write_reg(REG_SPEED_LIMIT, 8'($urandom_range(1, 31)));
      write_reg(REG_LEVER_ARM, 8'($urandom_range(1, 255)));
      if (k == 2) quiet = 1'b1;
      random_commands(70);
    end

    s_axis_tvalid = 1'b0;
    while (frames_sb.frames.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
    if (frames_sb.errors == 0) begin
      $display("omni_wheel_speed_packer_test: clean");
    end else begin
      $display("omni_wheel_speed_packer_test: errors");
    end
    $finish;
  end
endmodule
